// ===== design/chs_pkg.sv =====
// shared widths, register indexes and arithmetic helpers for the hermite curve core
package chs_pkg;

	localparam int COORD_W = 24;
	localparam int T_W     = 17;
	localparam int T_FRAC  = 16;
	localparam int OUT_W   = 32;
	localparam int ACC_W   = 34;
	localparam int PROD_W  = ACC_W + T_W + 1;
	localparam int IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_START_X       = 3'd0;
	localparam logic [IDX_W-1:0] REG_START_Y       = 3'd1;
	localparam logic [IDX_W-1:0] REG_END_X         = 3'd2;
	localparam logic [IDX_W-1:0] REG_END_Y         = 3'd3;
	localparam logic [IDX_W-1:0] REG_START_SLOPE_X = 3'd4;
	localparam logic [IDX_W-1:0] REG_START_SLOPE_Y = 3'd5;
	localparam logic [IDX_W-1:0] REG_END_SLOPE_X   = 3'd6;
	localparam logic [IDX_W-1:0] REG_END_SLOPE_Y   = 3'd7;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic signed [OUT_W-1:0]   out_t;
	typedef logic        [T_W-1:0]     t_t;
	typedef logic        [IDX_W-1:0]   idx_t;

	typedef struct packed {
		logic clip;
		out_t val;
	} sat_t;

	localparam acc_t ACC_OUT_MAX = acc_t'(2147483647);
	localparam acc_t ACC_OUT_MIN = acc_t'(-2147483647 - 1);
	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(2 ** (T_FRAC - 1));

	// c + floor((t * acc + half) / 2^16)
	function automatic acc_t horner_step(acc_t c, t_t t, acc_t acc);
		logic signed [PROD_W-1:0] prod;
		logic signed [PROD_W-1:0] rnd;
		prod = $signed({1'b0, t}) * acc;
		rnd  = (prod + RND_HALF) >>> T_FRAC;
		return c + $signed(rnd[ACC_W-1:0]);
	endfunction

	function automatic sat_t saturate(acc_t v);
		sat_t r;
		if (v > ACC_OUT_MAX) begin
			r.clip = 1'b1;
			r.val  = ACC_OUT_MAX[OUT_W-1:0];
		end else if (v < ACC_OUT_MIN) begin
			r.clip = 1'b1;
			r.val  = ACC_OUT_MIN[OUT_W-1:0];
		end else begin
			r.clip = 1'b0;
			r.val  = v[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/chs_axis.sv =====
// one axis of the curve: coefficient registers and the horner pipeline for position and slope
module chs_axis (
	input  logic           clk,
	input  chs_pkg::coord_t s,
	input  chs_pkg::coord_t e,
	input  chs_pkg::coord_t ts,
	input  chs_pkg::coord_t te,
	input  chs_pkg::t_t     t_s1,
	output chs_pkg::acc_t   pos_s4,
	output chs_pkg::acc_t   vel_s4
);
	import chs_pkg::*;

	acc_t s_w, e_w, ts_w, te_w;
	acc_t c2_d, c3_d;
	acc_t c0_q, c1_q, c2_q, c3_q, c2x2_q, c3x3_q;

	t_t   t_s2, t_s3;
	acc_t pa_s2, va_s2, pa_s3, va_s3, pa_s4, va_s4;

	assign s_w  = acc_t'(s);
	assign e_w  = acc_t'(e);
	assign ts_w = acc_t'(ts);
	assign te_w = acc_t'(te);

	assign c2_d = e_w + e_w + e_w - s_w - s_w - s_w - ts_w - ts_w - te_w;
	assign c3_d = s_w + s_w - e_w - e_w + ts_w + te_w;

	always_ff @(posedge clk) begin
		c0_q   <= s_w;
		c1_q   <= ts_w;
		c2_q   <= c2_d;
		c3_q   <= c3_d;
		c2x2_q <= c2_d + c2_d;
		c3x3_q <= c3_d + c3_d + c3_d;
	end

	always_ff @(posedge clk) begin
		t_s2  <= t_s1;
		pa_s2 <= horner_step(c2_q, t_s1, c3_q);
		va_s2 <= horner_step(c2x2_q, t_s1, c3x3_q);

		t_s3  <= t_s2;
		pa_s3 <= horner_step(c1_q, t_s2, pa_s2);
		va_s3 <= horner_step(c1_q, t_s2, va_s2);

		pa_s4 <= horner_step(c0_q, t_s3, pa_s3);
		va_s4 <= va_s3;
	end

	assign pos_s4 = pa_s4;
	assign vel_s4 = va_s4;

endmodule

// ===== design/cubic_hermite_point_and_tangent_core.sv =====
// top level of the two-axis cubic hermite point and tangent core
//
// Configuration: cfg_we writes cfg_data into register cfg_idx at the clock edge
// (start x/y, end x/y, start slope x/y, end slope x/y, all Q15.8). Write only
// while no beat is in flight. Reset clears all eight registers to zero.
// Command: a beat with parameter t (Q1.16) is taken at each edge with start high;
// busy is always low, so one beat can be taken every cycle.
// Result: done goes high for exactly one cycle per beat, together with pos_x,
// pos_y, vel_x, vel_y (Q23.8, saturated) and clipped. Results leave in the order
// the beats came in, one per beat.
// Pipeline: t register, three horner stages of one multiply and add each on
// every axis (position uses all three, slope the first two), then the
// saturation register. Throughput is one beat per cycle; the horner stages are
// separate registers so nothing is shared.
// The receiver cannot hold results off, so there is no stall path.
// Reset empties the pipeline; beats in flight are dropped.
module cubic_hermite_point_and_tangent_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  chs_pkg::t_t      t,
	output logic             done,
	output chs_pkg::out_t    pos_x,
	output chs_pkg::out_t    pos_y,
	output chs_pkg::out_t    vel_x,
	output chs_pkg::out_t    vel_y,
	output logic             clipped,
	input  logic             cfg_we,
	input  chs_pkg::idx_t    cfg_idx,
	input  chs_pkg::coord_t  cfg_data
);
	import chs_pkg::*;

	coord_t start_x_q, start_y_q, end_x_q, end_y_q;
	coord_t start_slope_x_q, start_slope_y_q, end_slope_x_q, end_slope_y_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	t_t   t_s1;
	acc_t px_s4, vx_s4, py_s4, vy_s4;
	sat_t px_sat, py_sat, vx_sat, vy_sat;
	out_t pos_x_s5, pos_y_s5, vel_x_s5, vel_y_s5;
	logic clip_s5;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q       <= '0;
			start_y_q       <= '0;
			end_x_q         <= '0;
			end_y_q         <= '0;
			start_slope_x_q <= '0;
			start_slope_y_q <= '0;
			end_slope_x_q   <= '0;
			end_slope_y_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_START_X:       start_x_q       <= cfg_data;
				REG_START_Y:       start_y_q       <= cfg_data;
				REG_END_X:         end_x_q         <= cfg_data;
				REG_END_Y:         end_y_q         <= cfg_data;
				REG_START_SLOPE_X: start_slope_x_q <= cfg_data;
				REG_START_SLOPE_Y: start_slope_y_q <= cfg_data;
				REG_END_SLOPE_X:   end_slope_x_q   <= cfg_data;
				REG_END_SLOPE_Y:   end_slope_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			t_s1 <= t;
		end
	end

	chs_axis u_axis_x (
		.clk    (clk),
		.s      (start_x_q),
		.e      (end_x_q),
		.ts     (start_slope_x_q),
		.te     (end_slope_x_q),
		.t_s1   (t_s1),
		.pos_s4 (px_s4),
		.vel_s4 (vx_s4)
	);

	chs_axis u_axis_y (
		.clk    (clk),
		.s      (start_y_q),
		.e      (end_y_q),
		.ts     (start_slope_y_q),
		.te     (end_slope_y_q),
		.t_s1   (t_s1),
		.pos_s4 (py_s4),
		.vel_s4 (vy_s4)
	);

	assign px_sat = saturate(px_s4);
	assign py_sat = saturate(py_s4);
	assign vx_sat = saturate(vx_s4);
	assign vy_sat = saturate(vy_s4);

	always_ff @(posedge clk) begin
		if (vld_s4) begin
			pos_x_s5 <= px_sat.val;
			pos_y_s5 <= py_sat.val;
			vel_x_s5 <= vx_sat.val;
			vel_y_s5 <= vy_sat.val;
			clip_s5  <= px_sat.clip | py_sat.clip | vx_sat.clip | vy_sat.clip;
		end
	end

	assign done    = vld_s5;
	assign pos_x   = pos_x_s5;
	assign pos_y   = pos_y_s5;
	assign vel_x   = vel_x_s5;
	assign vel_y   = vel_y_s5;
	assign clipped = clip_s5;

endmodule

// ===== design/chs_check.sv =====
// port-level checks for the hermite curve core, bound to the top level
module chs_check (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input logic          clipped,
	input chs_pkg::out_t pos_x,
	input chs_pkg::out_t pos_y,
	input chs_pkg::out_t vel_x,
	input chs_pkg::out_t vel_y
);
	import chs_pkg::*;

	localparam out_t OMAX = ACC_OUT_MAX[OUT_W-1:0];
	localparam out_t OMIN = ACC_OUT_MIN[OUT_W-1:0];

	// every accepted beat is followed by its result
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("accepted beat produced no result");

	// no result without a matching beat accepted before it
	a_lat_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("result without a matching beat");

	// a clipped result carries at least one value at a bound
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clipped) |-> (pos_x == OMAX || pos_x == OMIN || pos_y == OMAX
			|| pos_y == OMIN || vel_x == OMAX || vel_x == OMIN
			|| vel_y == OMAX || vel_y == OMIN))
		else $error("clipped set with no saturated value");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

endmodule

bind cubic_hermite_point_and_tangent_core chs_check u_chs_check (.*);

// ===== tb/cubic_hermite_point_and_tangent_core_test.sv =====
// testbench for the cubic hermite point and tangent core: directed table, then random curves
`timescale 1ns / 100ps

module cubic_hermite_point_and_tangent_core_test;

	import chs_pkg::*;

	typedef struct packed {
		out_t pos_x;
		out_t pos_y;
		out_t vel_x;
		out_t vel_y;
		logic clipped;
	} curve_point_t;

	typedef enum logic [0:0] {ROW_CFG, ROW_BEAT} row_kind_e;

	typedef struct packed {
		row_kind_e    kind;
		idx_t         idx;
		coord_t       data;
		t_t           tv;
		logic         typed;
		curve_point_t want;
	} stim_row_t;

	localparam coord_t C_MAX = 24'sh7FFFFF;
	localparam coord_t C_MIN = 24'sh800000;
	localparam out_t   O_MAX = 32'sd8388607;
	localparam out_t   O_MIN = -32'sd8388608;
	localparam t_t     T_ONE = 17'd65536;
	localparam t_t     T_TOP = 17'd131071;
	localparam int     N_ROWS = 30;
	localparam int     N_PHASES = 9;
	localparam int     BEATS_PER_PHASE = 100;

	// t = 0 gives the start point and start tangent, t = 1.0 the end point and end tangent
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		'{ROW_BEAT, REG_START_X, '0, 17'd0, 1'b1, '0},
		'{ROW_BEAT, REG_START_X, '0, T_ONE, 1'b1, '0},
		'{ROW_BEAT, REG_START_X, '0, T_TOP, 1'b1, '0},
		'{ROW_CFG, REG_START_X, C_MAX, 17'd0, 1'b0, '0},
		'{ROW_CFG, REG_START_Y, C_MIN, 17'd0, 1'b0, '0},
		'{ROW_CFG, REG_END_X, C_MIN, 17'd0, 1'b0, '0},
		'{ROW_CFG, REG_END_Y, C_MAX, 17'd0, 1'b0, '0},
		'{ROW_CFG, REG_START_SLOPE_X, C_MAX, 17'd0, 1'b0, '0},
		'{ROW_CFG, REG_START_SLOPE_Y, C_MIN, 17'd0, 1'b0, '0},
		'{ROW_CFG, REG_END_SLOPE_X, C_MIN, 17'd0, 1'b0, '0},
		'{ROW_CFG, REG_END_SLOPE_Y, C_MAX, 17'd0, 1'b0, '0},
		'{ROW_BEAT, REG_START_X, '0, 17'd0, 1'b1, '{O_MAX, O_MIN, O_MAX, O_MIN, 1'b0}},
		'{ROW_BEAT, REG_START_X, '0, T_ONE, 1'b1, '{O_MIN, O_MAX, O_MIN, O_MAX, 1'b0}},
		'{ROW_BEAT, REG_START_X, '0, T_TOP, 1'b0, '0},
		'{ROW_BEAT, REG_START_X, '0, 17'd1, 1'b0, '0},
		'{ROW_BEAT, REG_START_X, '0, 17'd32768, 1'b0, '0},
		'{ROW_BEAT, REG_START_X, '0, 17'd65535, 1'b0, '0},
		'{ROW_BEAT, REG_START_X, '0, 17'd98304, 1'b0, '0},
		'{ROW_CFG, REG_START_X, C_MIN, 17'd0, 1'b0, '0},
		'{ROW_CFG, REG_START_Y, C_MAX, 17'd0, 1'b0, '0},
		'{ROW_CFG, REG_END_X, C_MAX, 17'd0, 1'b0, '0},
		'{ROW_CFG, REG_END_Y, C_MIN, 17'd0, 1'b0, '0},
		'{ROW_CFG, REG_START_SLOPE_X, C_MAX, 17'd0, 1'b0, '0},
		'{ROW_CFG, REG_START_SLOPE_Y, C_MAX, 17'd0, 1'b0, '0},
		'{ROW_CFG, REG_END_SLOPE_X, C_MAX, 17'd0, 1'b0, '0},
		'{ROW_CFG, REG_END_SLOPE_Y, C_MIN, 17'd0, 1'b0, '0},
		'{ROW_BEAT, REG_START_X, '0, 17'd0, 1'b1, '{O_MIN, O_MAX, O_MAX, O_MAX, 1'b0}},
		'{ROW_BEAT, REG_START_X, '0, T_ONE, 1'b1, '{O_MAX, O_MIN, O_MAX, O_MIN, 1'b0}},
		'{ROW_BEAT, REG_START_X, '0, T_TOP, 1'b0, '0},
		'{ROW_BEAT, REG_START_X, '0, 17'd16384, 1'b0, '0}
	};

	logic   clk = 1'b0;
	logic   arst_n;
	logic   start;
	logic   busy;
	t_t     t;
	logic   done;
	out_t   pos_x;
	out_t   pos_y;
	out_t   vel_x;
	out_t   vel_y;
	logic   clipped;
	logic   cfg_we;
	idx_t   cfg_idx;
	coord_t cfg_data;

	coord_t       curve_regs [8];
	curve_point_t expected_points [$];
	int           mismatches = 0;
	bit           no_gaps = 1'b0;

	cubic_hermite_point_and_tangent_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.t(t),
		.done(done),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.vel_x(vel_x),
		.vel_y(vel_y),
		.clipped(clipped),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scales a product of t and acc back by 2^16, rounding half up
	function automatic longint t_scale(longint prod);
		return (prod + 64'sd32768) >>> T_FRAC;
	endfunction

	function automatic void eval_axis(input longint s, input longint e, input longint ts,
			input longint te, input longint tv, output longint p, output longint v);
		longint c2;
		longint c3;
		longint acc;
		c2 = 3 * e - 3 * s - 2 * ts - te;
		c3 = 2 * s - 2 * e + ts + te;
		acc = c2 + t_scale(tv * c3);
		acc = ts + t_scale(tv * acc);
		p = s + t_scale(tv * acc);
		acc = 2 * c2 + t_scale(tv * 3 * c3);
		v = ts + t_scale(tv * acc);
	endfunction

	function automatic out_t clamp_q23(input longint v, inout logic clip);
		if (v > 64'sd2147483647) begin
			clip = 1'b1;
			return 32'sh7FFFFFFF;
		end
		if (v < -64'sd2147483648) begin
			clip = 1'b1;
			return 32'sh80000000;
		end
		return out_t'(v);
	endfunction

	function automatic curve_point_t hermite_point(input t_t tv);
		curve_point_t r;
		longint px;
		longint py;
		longint vx;
		longint vy;
		logic clip;
		clip = 1'b0;
		eval_axis(longint'(curve_regs[REG_START_X]), longint'(curve_regs[REG_END_X]),
			longint'(curve_regs[REG_START_SLOPE_X]), longint'(curve_regs[REG_END_SLOPE_X]),
			longint'(tv), px, vx);
		eval_axis(longint'(curve_regs[REG_START_Y]), longint'(curve_regs[REG_END_Y]),
			longint'(curve_regs[REG_START_SLOPE_Y]), longint'(curve_regs[REG_END_SLOPE_Y]),
			longint'(tv), py, vy);
		r.pos_x = clamp_q23(px, clip);
		r.pos_y = clamp_q23(py, clip);
		r.vel_x = clamp_q23(vx, clip);
		r.vel_y = clamp_q23(vy, clip);
		r.clipped = clip;
		return r;
	endfunction

	function automatic coord_t pick_coord(input int phase);
		int style;
		style = (phase == 0) ? 0 : (phase == 1) ? 1 : (phase == 2) ? 2 : $urandom_range(3);
		case (style)
			0: return C_MAX;
			1: return C_MIN;
			2: return coord_t'($urandom_range(1023)) - coord_t'(512);
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic wait_drained();
		start <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input idx_t idx, input coord_t data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		curve_regs[idx] = data;
	endtask

	task automatic send_beat(input t_t tv, input curve_point_t typed_want, input logic typed);
		while (!no_gaps && $urandom_range(99) < 28) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		t <= tv;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_points.push_back(typed ? typed_want : hermite_point(tv));
	endtask

	task automatic check_field(input string name, input out_t want, input out_t got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		curve_point_t want;
		if (done === 1'b1) begin
			if (expected_points.size() == 0) begin
				$error("result beat with nothing expected");
				mismatches++;
			end else begin
				want = expected_points.pop_front();
				check_field("pos_x", want.pos_x, pos_x);
				check_field("pos_y", want.pos_y, pos_y);
				check_field("vel_x", want.vel_x, vel_x);
				check_field("vel_y", want.vel_y, vel_y);
				check_field("clipped", out_t'(want.clipped), out_t'(clipped));
			end
		end
	end

	initial begin
		t_t tv;
		bit sweep;
		arst_n <= 1'b0;
		start <= 1'b0;
		t <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_START_X;
		cfg_data <= '0;
		foreach (curve_regs[i])
			curve_regs[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				wait_drained();
				write_reg(DIRECTED[i].idx, DIRECTED[i].data);
			end else begin
				if (cfg_we)
					cfg_we <= 1'b0;
				send_beat(DIRECTED[i].tv, DIRECTED[i].want, DIRECTED[i].typed);
			end
		end

		for (int phase = 0; phase < N_PHASES; phase++) begin
			wait_drained();
			for (int r = 0; r < 8; r++)
				write_reg(idx_t'(r), pick_coord(phase));
			cfg_we <= 1'b0;
			no_gaps = (phase == 4);
			sweep = $urandom_range(1);
			tv = t_t'($urandom_range(4095));
			for (int n = 0; n < BEATS_PER_PHASE; n++) begin
				if (sweep) begin
					// a path drawn along the curve, t climbing in random steps
					tv = (tv > T_TOP - 17'd2048) ? t_t'($urandom_range(64)) :
						tv + t_t'($urandom_range(1, 2048));
				end else begin
					case ($urandom_range(9))
						0: tv = '0;
						1: tv = T_ONE;
						2: tv = T_TOP;
						3: tv = T_ONE + t_t'($urandom_range(16)) - t_t'(8);
						default: tv = t_t'($urandom_range(131071));
					endcase
				end
				send_beat(tv, '0, 1'b0);
			end
		end
		no_gaps = 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
